/* rtl/pwm_tone_divider_calc_core_defines.svh */
// Assertion macros for the PWM tone divider calculation block.
// No dependencies; included by the checker module.
`ifndef PWM_TONE_DIVIDER_CALC_CORE_DEFINES_SVH
`define PWM_TONE_DIVIDER_CALC_CORE_DEFINES_SVH

// Assertion checked at every clock edge outside reset.
`define PDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

/* rtl/pdc_pkg.sv */
// Package for the PWM tone divider calculation block: widths, payload types.
// No dependencies; used by the top level, the checker and the testbench.
package pdc_pkg;

  localparam int unsigned CLK_W            = 28;
  localparam int unsigned DUTY_W           = 16;
  localparam int unsigned CDIV_W           = 17;
  localparam int unsigned WRAP_OUT_W       = 12;
  localparam int unsigned COUNT_RANGE_DEF  = 4096;
  localparam logic [CLK_W-1:0] CLOCK_RESET = 28'd125000000;

  typedef struct packed {
    logic [CLK_W-1:0]  tone_hz;
    logic [DUTY_W-1:0] duty;
  } pdc_in_t;

  typedef struct packed {
    logic [CDIV_W-1:0]     clock_divider;
    logic [WRAP_OUT_W-1:0] wrap_value;
    logic [WRAP_OUT_W-1:0] compare_level;
    logic                  bad_freq;
  } pdc_out_t;

endpackage

/* rtl/pdc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; carries a valid bit and side data along the stages.
module pdc_div #(
  parameter int unsigned NUM_W  = 28,
  parameter int unsigned DEN_W  = 28,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [1:NUM_W];
  logic [NUM_W-1:0]  num_q  [1:NUM_W-1];
  logic [DEN_W-1:0]  den_q  [1:NUM_W-1];
  logic [DEN_W-1:0]  rem_q  [1:NUM_W-1];
  logic [NUM_W-1:0]  quo_q  [1:NUM_W];
  logic [SIDE_W-1:0] side_q [1:NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              vld_s;
    logic [NUM_W-1:0]  num_s;
    logic [DEN_W-1:0]  den_s;
    logic [DEN_W-1:0]  rem_s;
    logic [NUM_W-1:0]  quo_s;
    logic [SIDE_W-1:0] side_s;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W-1:0]  rem_d;
    logic [NUM_W-1:0]  quo_d;

    if (s == 0) begin : g_head
      assign vld_s  = valid_i;
      assign num_s  = num_i;
      assign den_s  = den_i;
      assign rem_s  = '0;
      assign quo_s  = '0;
      assign side_s = side_i;
    end else begin : g_body
      assign vld_s  = vld_q[s];
      assign num_s  = num_q[s];
      assign den_s  = den_q[s];
      assign rem_s  = rem_q[s];
      assign quo_s  = quo_q[s];
      assign side_s = side_q[s];
    end

    always_comb begin
      trial = {rem_s, num_s[NUM_W-1-s]};
      ge    = trial >= {1'b0, den_s};
      rem_d = ge ? DEN_W'(trial - {1'b0, den_s}) : DEN_W'(trial);
      quo_d = {quo_s[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s+1]  <= quo_d;
        side_q[s+1] <= side_s;
      end
    end

    if (s < NUM_W-1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[s+1] <= num_s;
          den_q[s+1] <= den_s;
          rem_q[s+1] <= rem_d;
        end
      end
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quo_o   = quo_q[NUM_W];
  assign side_o  = side_q[NUM_W];

endmodule

/* rtl/pwm_tone_divider_calc_core.sv */
// Top level of the PWM tone divider calculation block.
// Depends on pdc_pkg and pdc_div.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_data_i) carries tone_hz and
//   duty; output channel (out_valid_o, out_stall_i, out_data_o) carries
//   clock_divider, wrap_value, compare_level and bad_freq. A transfer occurs
//   when valid is high and stall is low. cfg_we_i writes clock_hz from
//   cfg_data_i; write it only while the block is empty.
//   The pipeline is two 28-stage bit-per-stage dividers (clock/tone, then
//   quotient/divider) and one multiply/output stage.
//   Throughput is one item per cycle while out_stall_i does not hold the output.
//   A tone of zero or above clock_hz gives bad_freq and zero settings.
//   Reset empties the pipeline and sets clock_hz to 125000000.
//   While the output is held by out_stall_i the whole pipeline freezes and
//   in_stall_o is raised; nothing is dropped or repeated.
//   COUNT_RANGE must be a power of two.
module pwm_tone_divider_calc_core import pdc_pkg::*; #(
  parameter int unsigned COUNT_RANGE = COUNT_RANGE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CLK_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pdc_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pdc_out_t         out_data_o
);

  localparam int unsigned SH     = $clog2(COUNT_RANGE);
  localparam int unsigned DIV_W  = CLK_W - SH + 1;
  localparam int unsigned WRAP_W = SH;
  localparam int unsigned S1_W   = DUTY_W + 1;
  localparam int unsigned S2_W   = DIV_W + DUTY_W + 1;

  logic [CLK_W-1:0] clock_q;
  logic             en;
  logic             out_valid_q;
  pdc_out_t         out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= CLOCK_RESET;
    end else if (cfg_we_i) begin
      clock_q <= cfg_data_i;
    end
  end

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage group 1: q = clock / tone
  logic             bad_in;
  logic [CLK_W-1:0] den1;
  logic             v1;
  logic [CLK_W-1:0] q1;
  logic [S1_W-1:0]  side1;

  assign bad_in = (in_data_i.tone_hz == '0) || (in_data_i.tone_hz > clock_q);
  assign den1   = bad_in ? CLK_W'(1) : in_data_i.tone_hz;

  pdc_div #(.NUM_W(CLK_W), .DEN_W(CLK_W), .SIDE_W(S1_W)) u_div_q (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i && !in_stall_o),
    .num_i(clock_q), .den_i(den1), .side_i({bad_in, in_data_i.duty}),
    .valid_o(v1), .quo_o(q1), .side_o(side1)
  );

  // Stage group 2: wrap + 1 = q / divider
  logic [DIV_W-1:0] cdiv;
  logic             v2;
  logic [CLK_W-1:0] q2;
  logic [S2_W-1:0]  side2;

  assign cdiv = DIV_W'(q1 >> SH) + DIV_W'(1);

  pdc_div #(.NUM_W(CLK_W), .DEN_W(DIV_W), .SIDE_W(S2_W)) u_div_w (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v1),
    .num_i(q1), .den_i(cdiv), .side_i({cdiv, side1}),
    .valid_o(v2), .quo_o(q2), .side_o(side2)
  );

  // Output stage: compare level
  logic                     bad2;
  logic [DUTY_W-1:0]        duty2;
  logic [DIV_W-1:0]         cdiv2;
  logic [WRAP_W-1:0]        wrap;
  logic [WRAP_W+DUTY_W-1:0] prod;
  pdc_out_t                 out_d;

  always_comb begin
    bad2  = side2[DUTY_W];
    duty2 = side2[DUTY_W-1:0];
    cdiv2 = side2[S2_W-1:DUTY_W+1];
    wrap  = WRAP_W'(q2 - CLK_W'(1));
    prod  = (WRAP_W+DUTY_W)'(wrap) * (WRAP_W+DUTY_W)'(duty2);
    if (bad2) begin
      out_d = '0;
      out_d.bad_freq = 1'b1;
    end else begin
      out_d.clock_divider = CDIV_W'(cdiv2);
      out_d.wrap_value    = WRAP_OUT_W'(wrap);
      out_d.compare_level = WRAP_OUT_W'(prod >> DUTY_W);
      out_d.bad_freq      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/pdc_checker.sv */
// Port-level checker for pwm_tone_divider_calc_core, bound to the top level.
// Depends on pdc_pkg and pwm_tone_divider_calc_core_defines.svh.
`include "pwm_tone_divider_calc_core_defines.svh"
module pdc_checker import pdc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [CLK_W-1:0] cfg_data_i,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input pdc_in_t          in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input pdc_out_t         out_data_o
);

  `PDC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled output transfer changed")
  `PDC_ASSERT(a_bad_zero, clk_i, rst_ni, out_valid_o && out_data_o.bad_freq |-> out_data_o.clock_divider == '0 && out_data_o.wrap_value == '0 && out_data_o.compare_level == '0, "bad frequency with nonzero settings")
  `PDC_ASSERT(a_cmp_le_wrap, clk_i, rst_ni, out_valid_o && !out_data_o.bad_freq |-> out_data_o.compare_level <= out_data_o.wrap_value, "compare level above wrap")
  `PDC_ASSERT(a_in_stall, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output backpressure")

endmodule

bind pwm_tone_divider_calc_core pdc_checker u_pdc_checker (.*);

/* test/pwm_tone_divider_calc_core_tb.sv */
// Testbench for pwm_tone_divider_calc_core: random and directed tone/duty transfers
// checked against an in-bench divider/wrap/compare calculation. Depends on pdc_pkg.
module pwm_tone_divider_calc_core_tb;
  import pdc_pkg::*;

  localparam int unsigned LATENCY  = 57;
  localparam int unsigned HOLD_LEN = 300;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CLK_W-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            in_taken = 1'b0;
  pdc_in_t         in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  pdc_out_t        out_data;

  pdc_in_t  tone_queue[$];
  pdc_out_t settings_queue[$];
  logic [CLK_W-1:0] clock_hz_q = CLOCK_RESET;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_cnt = 0;
  int unsigned errors = 0;

  always #5 clk = ~clk;

  pwm_tone_divider_calc_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  function automatic pdc_out_t calc_settings(pdc_in_t item, logic [CLK_W-1:0] clk_hz);
    pdc_out_t r;
    longint unsigned q, dv, wr, cm;
    r = '0;
    if (item.tone_hz == 0 || item.tone_hz > clk_hz) begin
      r.bad_freq = 1'b1;
    end else begin
      q  = longint'(clk_hz) / longint'(item.tone_hz);
      dv = q / COUNT_RANGE_DEF + 1;
      wr = q / dv - 1;
      cm = (wr * longint'(item.duty)) >> 16;
      r.clock_divider = dv[CDIV_W-1:0];
      r.wrap_value    = wr[WRAP_OUT_W-1:0];
      r.compare_level = cm[WRAP_OUT_W-1:0];
    end
    return r;
  endfunction

  // Driver: holds payload until the transfer is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (tone_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= tone_queue[0];
          in_valid <= 1'b1;
          void'(tone_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: long hold counted here, random stalls otherwise.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_cnt  <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Monitor: predicts on input transfer, checks on output transfer.
  always @(posedge clk) begin
    pdc_out_t exp_r;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        settings_queue.push_back(calc_settings(in_data, clock_hz_q));
      if (out_valid && !out_stall) begin
        if (settings_queue.size() == 0) begin
          $error("unexpected output transfer %h", out_data);
          errors++;
        end else begin
          exp_r = settings_queue.pop_front();
          if (out_data.clock_divider !== exp_r.clock_divider) begin
            $error("clock_divider exp %0d got %0d", exp_r.clock_divider,
                   out_data.clock_divider);
            errors++;
          end
          if (out_data.wrap_value !== exp_r.wrap_value) begin
            $error("wrap_value exp %0d got %0d", exp_r.wrap_value, out_data.wrap_value);
            errors++;
          end
          if (out_data.compare_level !== exp_r.compare_level) begin
            $error("compare_level exp %0d got %0d", exp_r.compare_level,
                   out_data.compare_level);
            errors++;
          end
          if (out_data.bad_freq !== exp_r.bad_freq) begin
            $error("bad_freq exp %0d got %0d", exp_r.bad_freq, out_data.bad_freq);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_item(logic [CLK_W-1:0] tone, logic [DUTY_W-1:0] duty);
    pdc_in_t it;
    it.tone_hz = tone;
    it.duty    = duty;
    tone_queue.push_back(it);
  endtask

  task automatic drain();
    while (tone_queue.size() > 0 || in_valid || settings_queue.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_clock(logic [CLK_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(negedge clk);
    cfg_we     <= 1'b0;
    clock_hz_q = val;
  endtask

  task automatic add_random(int unsigned n);
    logic [CLK_W-1:0] t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: t = CLK_W'($urandom());
        1: t = CLK_W'($urandom_range(40000, 1));
        2: t = clock_hz_q - CLK_W'($urandom_range(3)) + CLK_W'($urandom_range(3));
        3: t = CLK_W'($urandom_range(1000, 0));
        default: t = (clock_hz_q >> $urandom_range(27)) + CLK_W'($urandom_range(2));
      endcase
      add_item(t, DUTY_W'($urandom()));
    end
  endtask

  initial begin
    logic [CLK_W-1:0] clocks[5];
    clocks = '{28'd125000000, 28'hFFFFFFF, 28'd1, 28'd0, 28'd48000000};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_item(28'd0, 16'hFFFF);
    add_item(28'd1, 16'hFFFF);
    add_item(28'd1, 16'h0000);
    add_item(28'hFFFFFFF, 16'h8000);
    add_item(CLOCK_RESET, 16'hFFFF);
    add_item(CLOCK_RESET + 28'd1, 16'hFFFF);
    add_item(28'd440, 16'h8000);
    add_item(28'd30, 16'h5555);
    add_item(28'd30517, 16'hAAAA);
    add_item(28'd30518, 16'h0001);
    add_item(28'd1000, 16'hFFFF);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_clock(clocks[p]);
      send_idle_pct  = (p == 1 || p == 4) ? 58 : (p == 3 ? 10 : 0);
      recv_stall_pct = (p == 2 || p == 4) ? 58 : (p == 3 ? 10 : 0);
      if (p == 1)
        hold_req = hold_req + 1;
      add_random(225);
      drain();
    end
    write_clock(CLOCK_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random(20);
    drain();

    if (errors == 0)
      $display("pwm_tone_divider_calc_core test passed");
    else
      $display("pwm_tone_divider_calc_core test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("pwm_tone_divider_calc_core test failed");
    $finish;
  end
endmodule
